### hdl/isne_pkg.sv
// ----------------------------------------------------------------------------
// isne_pkg: shared types and constants of the stream node evaluator
// Operation codes, compare codes, register indexes and divider sizes.
// ----------------------------------------------------------------------------
package isne_pkg;

   localparam int DataBits     = 32;
   localparam int PercentFull  = 100;

   // Knee division: a 40-bit numerator over a 33-bit span. The quotient is
   // always below 100, so seven quotient bits are enough.
   localparam int DivNumBits   = 40;
   localparam int DivDenBits   = 33;
   localparam int KneeQuotBits = 7;
   localparam int KneeCntBits  = $clog2(KneeQuotBits);

   // Operation codes held in op_mode.
   localparam logic [3:0] MODE_PASS    = 4'd0;
   localparam logic [3:0] MODE_EMIT    = 4'd1;
   localparam logic [3:0] MODE_MUL     = 4'd2;
   localparam logic [3:0] MODE_ADD     = 4'd3;
   localparam logic [3:0] MODE_SUB     = 4'd4;
   localparam logic [3:0] MODE_NEG     = 4'd5;
   localparam logic [3:0] MODE_GATE_GT = 4'd6;
   localparam logic [3:0] MODE_GATE_LT = 4'd7;
   localparam logic [3:0] MODE_GATE_EQ = 4'd8;
   localparam logic [3:0] MODE_GATE_GE = 4'd9;
   localparam logic [3:0] MODE_GATE_LE = 4'd10;
   localparam logic [3:0] MODE_KNEE    = 4'd11;
   localparam logic [3:0] MODE_DELTA   = 4'd12;
   localparam logic [3:0] MODE_SUST    = 4'd13;
   localparam logic [3:0] MODE_SUM     = 4'd14;

   // Compare codes held in compare_kind.
   localparam logic [2:0] CMP_GT = 3'd0;
   localparam logic [2:0] CMP_LT = 3'd1;
   localparam logic [2:0] CMP_EQ = 3'd2;
   localparam logic [2:0] CMP_GE = 3'd3;
   localparam logic [2:0] CMP_LE = 3'd4;

   // Configuration register indexes.
   localparam logic [1:0] REG_OP_MODE      = 2'd0;
   localparam logic [1:0] REG_OPERAND_A    = 2'd1;
   localparam logic [1:0] REG_OPERAND_B    = 2'd2;
   localparam logic [1:0] REG_COMPARE_KIND = 2'd3;

   // Status of the shared divider as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

### hdl/isne_div.sv
// ----------------------------------------------------------------------------
// isne_div: iterative restoring divider
// One compare and subtract per cycle, one quotient bit per step.
// ----------------------------------------------------------------------------
module isne_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [isne_pkg::DivNumBits-1:0]      num,
   input  logic [isne_pkg::DivDenBits-1:0]      den,
   output isne_pkg::div_stat_type               stat,
   output logic [isne_pkg::KneeQuotBits-1:0]    quot
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [isne_pkg::KneeCntBits-1:0]    cnt_ff, cnt_in;
   logic [isne_pkg::DivNumBits-1:0]     rem_ff, rem_in;
   logic [isne_pkg::DivNumBits-1:0]     dvs_ff, dvs_in;
   logic [isne_pkg::KneeQuotBits-1:0]   quot_ff, quot_in;
   logic                                fits;

   assign fits = rem_ff >= dvs_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = isne_pkg::KneeCntBits'(isne_pkg::KneeQuotBits - 1);
         rem_in  = num;
         // Divisor starts aligned with the top quotient bit.
         dvs_in  = isne_pkg::DivNumBits'(den) << (isne_pkg::KneeQuotBits - 1);
         quot_in = '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dvs_ff;
         end
         quot_in = {quot_ff[isne_pkg::KneeQuotBits-2:0], fits};
         dvs_in  = dvs_ff >> 1;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = quot_ff;

endmodule

### hdl/int32_stream_node_evaluator.sv
// ----------------------------------------------------------------------------
// int32_stream_node_evaluator: configurable per-word operation on a stream
// Each word is captured, computed in ST_CALC and, for a dividing knee word, run
// through the seven shared divider steps in ST_DIV, then moved from ST_DONE into
// the output register. Words are taken one at a time: the next only after the
// last result is loaded, which a stalled result register holds back in ST_DONE.
// Reset is synchronous and clears the configuration, the delta, hold and sum
// state, and the result valid flag.
// ----------------------------------------------------------------------------
module int32_stream_node_evaluator (
   input  logic        clock,
   input  logic        reset,
   // input words
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_sample,
   // result words
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_value,
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   // The sequencer walks each word through a compute state, an optional
   // division, and a final state that waits for the result register to drain.
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CALC = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type   state_ff, state_in;

   // Configuration registers.
   logic [3:0]  mode_ff;
   logic [31:0] opa_ff;
   logic [31:0] opb_ff;
   logic [2:0]  kind_ff;

   // Captured word and the computed result waiting for the output register.
   logic [31:0] sample_ff, sample_in;
   logic [31:0] res_ff, res_in;

   // State that lives across words.
   logic [31:0] prev_ff, prev_in;
   logic        prev_vld_ff, prev_vld_in;
   logic [31:0] hold_ff, hold_in;
   logic [31:0] total_ff, total_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff, rsp_value_in;

   // Shared divider.
   logic                                div_start;
   logic [isne_pkg::DivNumBits-1:0]     div_num;
   logic [isne_pkg::DivDenBits-1:0]     div_den;
   isne_pkg::div_stat_type              div_stat;
   logic [isne_pkg::KneeQuotBits-1:0]   div_quot;

   // Datapath helpers for the compute cycle.
   logic signed [31:0]                  s_sgn, a_sgn;
   logic [31:0]                         product;
   logic [isne_pkg::DivDenBits-1:0]     span_low;
   logic [isne_pkg::DivNumBits-1:0]     span_ext;
   logic                                sust_hit;
   logic [31:0]                         hold_next;
   logic                                hold_pass;
   logic                                out_free;

   function automatic logic cmp_by_kind(input logic [2:0] kind,
                                        input logic signed [31:0] v,
                                        input logic signed [31:0] t);
      logic r;
      unique case (kind)
         isne_pkg::CMP_LT: r = v < t;
         isne_pkg::CMP_EQ: r = v == t;
         isne_pkg::CMP_GE: r = v >= t;
         isne_pkg::CMP_LE: r = v <= t;
         default:          r = v > t;   // unused codes behave as greater-than
      endcase
      return r;
   endfunction

   isne_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .stat  (div_stat),
      .quot  (div_quot)
   );

   assign req_ready = state_ff == ST_IDLE;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign s_sgn   = sample_ff;
   assign a_sgn   = opa_ff;
   assign product = sample_ff * opa_ff;

   // Knee: the distance above the low bound times 100, built from shifts
   // (64 + 32 + 4), over the span between the bounds. Both are positive
   // whenever the division is actually started.
   assign span_low = {sample_ff[31], sample_ff} - {opa_ff[31], opa_ff};
   assign span_ext = isne_pkg::DivNumBits'(span_low);
   assign div_num  = (span_ext << 6) + (span_ext << 5) + (span_ext << 2);
   assign div_den  = {opb_ff[31], opb_ff} - {opa_ff[31], opa_ff};

   // Sustained: the counter saturates at all ones and the pass test compares
   // the updated count, as unsigned, against the signed required count.
   assign sust_hit  = cmp_by_kind(kind_ff, s_sgn, a_sgn);
   assign hold_next = sust_hit ? ((hold_ff == '1) ? hold_ff : hold_ff + 1'b1) : '0;
   assign hold_pass = $signed({1'b0, hold_next}) >= $signed({opb_ff[31], opb_ff});

   always_comb begin
      state_in     = state_ff;
      sample_in    = sample_ff;
      res_in       = res_ff;
      prev_in      = prev_ff;
      prev_vld_in  = prev_vld_ff;
      hold_in      = hold_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      div_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_sample;
               state_in  = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = ST_DONE;
            unique case (mode_ff)
               isne_pkg::MODE_PASS:    res_in = sample_ff;
               isne_pkg::MODE_EMIT:    res_in = opa_ff;
               isne_pkg::MODE_MUL:     res_in = product;
               isne_pkg::MODE_ADD:     res_in = sample_ff + opa_ff;
               isne_pkg::MODE_SUB:     res_in = sample_ff - opa_ff;
               isne_pkg::MODE_NEG:     res_in = 32'd0 - sample_ff;
               isne_pkg::MODE_GATE_GT: res_in = (s_sgn >  a_sgn) ? sample_ff : '0;
               isne_pkg::MODE_GATE_LT: res_in = (s_sgn <  a_sgn) ? sample_ff : '0;
               isne_pkg::MODE_GATE_EQ: res_in = (s_sgn == a_sgn) ? sample_ff : '0;
               isne_pkg::MODE_GATE_GE: res_in = (s_sgn >= a_sgn) ? sample_ff : '0;
               isne_pkg::MODE_GATE_LE: res_in = (s_sgn <= a_sgn) ? sample_ff : '0;
               isne_pkg::MODE_KNEE: begin
                  if (s_sgn <= a_sgn) begin
                     res_in = '0;
                  end else if (s_sgn >= $signed(opb_ff)) begin
                     // Also covers a low bound at or above the high bound.
                     res_in = 32'(isne_pkg::PercentFull);
                  end else begin
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end
               isne_pkg::MODE_DELTA: begin
                  res_in      = prev_vld_ff ? sample_ff - prev_ff : '0;
                  prev_in     = sample_ff;
                  prev_vld_in = 1'b1;
               end
               isne_pkg::MODE_SUST: begin
                  hold_in = hold_next;
                  res_in  = hold_pass ? sample_ff : '0;
               end
               isne_pkg::MODE_SUM: begin
                  total_in = total_ff + sample_ff;
                  res_in   = total_ff + sample_ff;
               end
               default: res_in = '0;   // unused mode: zero, no state change
            endcase
         end
         ST_DIV: begin
            if (div_stat.done) begin
               res_in   = 32'(div_quot);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= '0;
         opa_ff       <= '0;
         opb_ff       <= '0;
         kind_ff      <= '0;
         prev_ff      <= '0;
         prev_vld_ff  <= 1'b0;
         hold_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         prev_vld_ff  <= prev_vld_in;
         hold_ff      <= hold_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               isne_pkg::REG_OP_MODE:      mode_ff <= csr_data[3:0];
               isne_pkg::REG_OPERAND_A:    opa_ff  <= csr_data;
               isne_pkg::REG_OPERAND_B:    opb_ff  <= csr_data;
               isne_pkg::REG_COMPARE_KIND: kind_ff <= csr_data[2:0];
               default:                    mode_ff <= mode_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      res_ff       <= res_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   // The divider only runs while the sequencer waits for it.
   a_div_in_div_state: assert property (@(posedge clock) disable iff (reset)
      (div_stat.busy || div_stat.done) |-> state_ff == ST_DIV)
      else $error("divider active outside the division state");

   // A knee quotient is a percentage below full scale.
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> div_quot < isne_pkg::KneeQuotBits'(isne_pkg::PercentFull))
      else $error("knee quotient out of range");

   // An accepted word is always computed in the very next cycle.
   a_accept_to_calc: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == ST_CALC)
      else $error("accepted word not computed next cycle");

   // A new result word only appears out of the final sequencer state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !(rsp_valid_ff && !rsp_ready)) |-> state_ff == ST_DONE)
      else $error("result loaded outside the final state");

endmodule
